[hw/rtl/pvsnow_pkg.sv]
// Shared types, constants and the sine table of the snow coverage step.
`timescale 1ns / 1ps

package pvsnow_pkg;

    // Field widths
    localparam int DEPTH_W    = 15;
    localparam int LDEPTH_W   = 14;
    localparam int POA_W      = 11;
    localparam int TILT_W     = 11;
    localparam int TEMP_W     = 11;
    localparam int ROWS_W     = 8;
    localparam int LOSS_W     = 16;
    localparam int COUNT_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int MUL_W      = 32;

    // Coverage fraction bits used when the top level is not told otherwise
    localparam int COV_FRAC_BITS_DEFAULT = 15;

    // Largest valid depth, 610 cm in 1/16 cm
    localparam int MAX_VALID_DEPTH = 9760;

    // Slide amount divisor is 5 * 2^28: shift by 28, then divide by 5
    localparam int SLIDE_SHIFT = 28;
    localparam longint SLIDE_ROUND = 64'd5 << 27;
    localparam logic [MUL_W-1:0] RECIP_5 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 34;

    // Loss fraction: (covered << 15 + rows/2) / rows, one quotient bit per step
    localparam int LOSS_SHIFT = 15;
    localparam int LOSS_NUM_W = ROWS_W + LOSS_SHIFT;
    localparam int DIV_STEPS  = LOSS_NUM_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULE_ROWS        = 3'd0,
        CFG_BASE_TILT          = 3'd1,
        CFG_SNOWFALL_THRESHOLD = 3'd2,
        CFG_DEPTH_THRESHOLD    = 3'd3,
        CFG_IRRADIANCE_SLOPE   = 3'd4,
        CFG_SLIDE_RATE         = 3'd5,
        CFG_TIME_STEP          = 3'd6,
        CFG_BAD_VALUE_LIMIT    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]  module_rows;
        logic [10:0] base_tilt;
        logic [9:0]  snowfall_threshold;
        logic [9:0]  depth_threshold;
        logic [7:0]  irradiance_slope;
        logic [9:0]  slide_rate;
        logic [10:0] time_step;
        logic [15:0] bad_value_limit;
    } cfg_t;

    // Operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MUL_THR_TS     = 3'd0,
        MUL_TEMP_SLOPE = 3'd1,
        MUL_RATE_SINE  = 3'd2,
        MUL_PROD_TS    = 3'd3,
        MUL_RECIP      = 3'd4,
        MUL_COV_ROWS   = 3'd5
    } mul_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     check;
        logic     snow;
        logic     slide;
        logic     round_amt;
        logic     apply;
        logic     quantize;
        logic     div_step;
        logic     finish;
        mul_sel_t mul_sel;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fail;
        logic out_free;
    } status_t;

    // sin of whole degrees 0..90 in Q1.15
    localparam logic [15:0] SINE_Q15 [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31652, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    // Sine of a tilt in 1/16 degree, rounded to whole degrees, folded past 90
    function automatic logic [15:0] sine_of_tilt(input logic [TILT_W-1:0] tilt);
        logic [11:0] deg_sum;
        logic [7:0]  deg;
        deg_sum = {1'b0, tilt} + 12'd8;
        deg     = deg_sum[11:4];
        if (deg > 8'd180) begin
            deg = 8'd180;
        end
        if (deg > 8'd90) begin
            deg = 8'd180 - deg;
        end
        return SINE_Q15[deg[6:0]];
    endfunction

endpackage

[hw/rtl/pvsnow_ctrl.sv]
// Sequencer of the snow coverage step: walks the datapath through one sample.
`timescale 1ns / 1ps

module pvsnow_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pvsnow_pkg::status_t status,
    output pvsnow_pkg::cmd_t    cmd
);

    localparam int CNT_W = $clog2(pvsnow_pkg::DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SNOW,
        S_SLIDE,
        S_PROD,
        S_ROUND,
        S_RECIP,
        S_APPLY,
        S_ROWS,
        S_COVER,
        S_DIV,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Next state and command decode
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.mul_sel = pvsnow_pkg::MUL_THR_TS;
        s_tready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check   = 1'b1;
                cmd.mul_sel = pvsnow_pkg::MUL_THR_TS;
                state_next  = S_SNOW;
            end
            S_SNOW: begin
                // a failing sample skips straight to its result
                cmd.snow    = !status.fail;
                cmd.mul_sel = pvsnow_pkg::MUL_TEMP_SLOPE;
                state_next  = status.fail ? S_FINISH : S_SLIDE;
            end
            S_SLIDE: begin
                cmd.slide   = 1'b1;
                cmd.mul_sel = pvsnow_pkg::MUL_RATE_SINE;
                state_next  = S_PROD;
            end
            S_PROD: begin
                cmd.mul_sel = pvsnow_pkg::MUL_PROD_TS;
                state_next  = S_ROUND;
            end
            S_ROUND: begin
                cmd.round_amt = 1'b1;
                state_next    = S_RECIP;
            end
            S_RECIP: begin
                cmd.mul_sel = pvsnow_pkg::MUL_RECIP;
                state_next  = S_APPLY;
            end
            S_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = S_ROWS;
            end
            S_ROWS: begin
                cmd.mul_sel = pvsnow_pkg::MUL_COV_ROWS;
                state_next  = S_COVER;
            end
            S_COVER: begin
                cmd.quantize = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(pvsnow_pkg::DIV_STEPS - 1)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the output register can take the word
                cmd.finish = status.out_free;
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[hw/rtl/pvsnow_dp.sv]
// Datapath of the snow coverage step: state, shared multiplier, loss divider.
`timescale 1ns / 1ps

module pvsnow_dp #(
    parameter int COVERAGE_FRACTION_BITS = pvsnow_pkg::COV_FRAC_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pvsnow_pkg::cfg_t    cfg,
    input  pvsnow_pkg::cmd_t    cmd,
    output pvsnow_pkg::status_t status,
    input  logic [14:0]         snow_depth,
    input  logic                depth_missing,
    input  logic [10:0]         irradiance,
    input  logic [10:0]         panel_tilt,
    input  logic [10:0]         air_temp,
    input  logic                sun_up,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [15:0]         loss_fraction,
    output logic [7:0]          covered_rows,
    output logic                value_ok,
    output logic                model_failed
);

    localparam int F  = COVERAGE_FRACTION_BITS;
    localparam int CW = F + 1;
    localparam int XW = F + 38;
    localparam int NW = pvsnow_pkg::LOSS_NUM_W;
    localparam logic [CW-1:0] FULL    = CW'(1) << F;
    localparam logic [CW-1:0] FULL_M1 = FULL - CW'(1);

    // Sample registers
    logic [14:0] depth_reg;
    logic        missing_reg;
    logic [10:0] poa_reg, tilt_reg, temp_reg;
    logic        sun_reg;

    // Model state
    logic [15:0]   bad_count_reg;
    logic [13:0]   last_depth_reg;
    logic [CW-1:0] coverage_reg;

    // Working registers
    logic [13:0]   depth_eff_reg;
    logic          ok_reg, fail_reg, slide_reg;
    logic [15:0]   sine_reg;
    logic [CW-1:0] cov_work_reg;
    logic [31:0]   y_reg;
    logic [63:0]   mul_reg;
    logic [7:0]    covered_reg, rem_reg;
    logic [NW-1:0] num_reg;
    logic [15:0]   quot_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [15:0] loss_out_reg;
    logic [7:0]  rows_out_reg;
    logic        ok_out_reg, fail_out_reg;

    logic [7:0] rows_eff;
    assign rows_eff = (cfg.module_rows == 8'd0) ? 8'd1 : cfg.module_rows;

    // Depth check and bad count
    logic        bad, can_inc;
    logic [15:0] bad_inc;
    always_comb begin
        bad     = missing_reg || depth_reg[14]
                  || (depth_reg[13:0] > 14'(pvsnow_pkg::MAX_VALID_DEPTH));
        bad_inc = bad_count_reg + 16'd1;
        can_inc = bad && (bad_count_reg != 16'hFFFF);
    end

    // Snowfall and depth threshold tests
    logic [14:0]   diff;
    logic          rise_ok, depth_ok;
    logic [CW-1:0] cov_snow;
    always_comb begin
        diff     = {1'b0, depth_eff_reg} - {1'b0, last_depth_reg};
        rise_ok  = !diff[14] && ({3'b000, diff[13:0], 4'b0000} >= mul_reg[20:0]);
        depth_ok = depth_eff_reg >= 14'(cfg.depth_threshold);
        if (!depth_ok) begin
            cov_snow = '0;
        end else if (rise_ok) begin
            cov_snow = FULL;
        end else begin
            cov_snow = coverage_reg;
        end
    end

    // Sliding test: air_temp * slope + 16 * irradiance > 0
    logic [10:0] temp_mag;
    logic [14:0] poa16;
    logic        slide_now;
    always_comb begin
        temp_mag = temp_reg[10] ? (~temp_reg + 11'd1) : temp_reg;
        poa16    = {poa_reg, 4'b0000};
        if (temp_reg[10]) begin
            slide_now = {4'b0000, poa16} > mul_reg[18:0];
        end else begin
            slide_now = (mul_reg[18:0] != 19'd0) || (poa_reg != 11'd0);
        end
    end

    // Slide amount rounding, then the divide by five through its reciprocal
    logic [XW-1:0] slide_x;
    logic [29:0]   amount;
    always_comb begin
        slide_x = (XW'(mul_reg[36:0]) << F) + XW'(pvsnow_pkg::SLIDE_ROUND);
        amount  = mul_reg[63:pvsnow_pkg::RECIP_SHIFT];
    end

    // Rows covered, rounded up
    logic [CW+8:0] cov_sum;
    logic [7:0]    covered;
    always_comb begin
        cov_sum = (CW+9)'(mul_reg[CW+7:0]) + (CW+9)'(FULL_M1);
        covered = cov_sum[F+7:F];
    end

    // Restoring divide step for the loss fraction
    logic [8:0] trial;
    logic       q_bit;
    always_comb begin
        trial = {rem_reg, num_reg[NW-1]};
        q_bit = trial >= {1'b0, rows_eff};
    end

    // Shared multiplier operands
    logic [31:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            pvsnow_pkg::MUL_THR_TS: begin
                mul_a = 32'(cfg.snowfall_threshold);
                mul_b = 32'(cfg.time_step);
            end
            pvsnow_pkg::MUL_TEMP_SLOPE: begin
                mul_a = 32'(temp_mag);
                mul_b = 32'(cfg.irradiance_slope);
            end
            pvsnow_pkg::MUL_RATE_SINE: begin
                mul_a = 32'(cfg.slide_rate);
                mul_b = 32'(sine_reg);
            end
            pvsnow_pkg::MUL_PROD_TS: begin
                mul_a = 32'(mul_reg[25:0]);
                mul_b = 32'(cfg.time_step);
            end
            pvsnow_pkg::MUL_RECIP: begin
                mul_a = y_reg;
                mul_b = pvsnow_pkg::RECIP_5;
            end
            pvsnow_pkg::MUL_COV_ROWS: begin
                mul_a = 32'(cov_work_reg);
                mul_b = 32'(rows_eff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Working registers, no reset needed
    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
        if (cmd.load) begin
            depth_reg   <= snow_depth;
            missing_reg <= depth_missing;
            poa_reg     <= irradiance;
            tilt_reg    <= panel_tilt;
            temp_reg    <= air_temp;
            sun_reg     <= sun_up;
        end
        if (cmd.check) begin
            depth_eff_reg <= bad ? 14'd0 : depth_reg[13:0];
            ok_reg        <= !bad;
        end
        if (cmd.snow) begin
            cov_work_reg <= cov_snow;
            sine_reg     <= pvsnow_pkg::sine_of_tilt(sun_reg ? tilt_reg : cfg.base_tilt);
        end
        if (cmd.slide) begin
            slide_reg <= slide_now;
        end
        if (cmd.round_amt) begin
            y_reg <= 32'(slide_x[XW-1:pvsnow_pkg::SLIDE_SHIFT]);
        end
        if (cmd.apply && slide_reg) begin
            cov_work_reg <= (amount >= 30'(cov_work_reg)) ? '0
                                                          : cov_work_reg - CW'(amount);
        end
        if (cmd.quantize) begin
            covered_reg <= covered;
            rem_reg     <= '0;
            num_reg     <= {covered, {pvsnow_pkg::LOSS_SHIFT{1'b0}}} + NW'(rows_eff >> 1);
            quot_reg    <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= q_bit ? 8'(trial - {1'b0, rows_eff}) : trial[7:0];
            num_reg  <= num_reg << 1;
            quot_reg <= {quot_reg[14:0], q_bit};
        end
        if (cmd.finish) begin
            loss_out_reg <= fail_reg ? 16'd0 : quot_reg;
            rows_out_reg <= fail_reg ? 8'd0 : covered_reg;
            ok_out_reg   <= ok_reg;
            fail_out_reg <= fail_reg;
        end
    end

    // Model state, failure flag and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bad_count_reg  <= '0;
            last_depth_reg <= '0;
            coverage_reg   <= '0;
            fail_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.check) begin
                if (can_inc) begin
                    bad_count_reg <= bad_inc;
                end
                fail_reg <= can_inc && (bad_inc == cfg.bad_value_limit);
            end
            // a failed step leaves depth and coverage as they were
            if (cmd.finish && !fail_reg) begin
                last_depth_reg <= depth_eff_reg;
                coverage_reg   <= cov_work_reg;
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.fail     = fail_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid      = m_tvalid_reg;
    assign loss_fraction = loss_out_reg;
    assign covered_rows  = rows_out_reg;
    assign value_ok      = ok_out_reg;
    assign model_failed  = fail_out_reg;

endmodule

[hw/rtl/pv_snow_coverage_step.sv]
// Top level of the snow coverage step: ports, configuration registers, checks.
`timescale 1ns / 1ps

// Takes one weather sample per word and returns one result word per sample:
// the loss fraction (Q1.15) and module rows covered by snow, a valid-depth
// flag and a failure flag raised when the bad-depth count reaches its limit.
// A sample is worked one at a time: the result enters the output register once
// the sample's steps are done, and the next sample can be accepted in the cycle
// after; a failing sample skips straight to its result. Most of the work is the
// loss-fraction divider, which retires one of 23 quotient bits per
// cycle; the remaining steps run through one 32x32 multiplier shared by all
// products. A waiting result does not block the next sample from being taken.
// Configuration writes are always accepted and must only be issued while the
// block holds no sample in flight.
module pv_snow_coverage_step #(
    parameter int COVERAGE_FRACTION_BITS = pvsnow_pkg::COV_FRAC_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    // snow_depth[14:0], irradiance[25:15], panel_tilt[36:26], air_temp[47:37],
    // sun_up[48], zero[55:49]
    input  logic [55:0] s_tdata,
    // depth_missing[0]
    input  logic [0:0]  s_tuser,
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    // loss_fraction[15:0], covered_rows[23:16]
    output logic [23:0] m_tdata,
    // value_ok[0], model_failed[1]
    output logic [1:0]  m_tuser,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    pvsnow_pkg::cfg_t    cfg_reg;
    pvsnow_pkg::cmd_t    cmd;
    pvsnow_pkg::status_t status;

    logic [15:0] loss_fraction;
    logic [7:0]  covered_rows;
    logic        value_ok, model_failed;

    // Configuration register file
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.module_rows        <= 8'd2;
            cfg_reg.base_tilt          <= 11'd480;
            cfg_reg.snowfall_threshold <= 10'd16;
            cfg_reg.depth_threshold    <= 10'd16;
            cfg_reg.irradiance_slope   <= 8'd80;
            cfg_reg.slide_rate         <= 10'd504;
            cfg_reg.time_step          <= 11'd16;
            cfg_reg.bad_value_limit    <= 16'd500;
        end else if (cfg_valid && cfg_ready) begin
            unique case (pvsnow_pkg::cfg_reg_t'(cfg_index))
                pvsnow_pkg::CFG_MODULE_ROWS:        cfg_reg.module_rows <= cfg_data[7:0];
                pvsnow_pkg::CFG_BASE_TILT:          cfg_reg.base_tilt <= cfg_data[10:0];
                pvsnow_pkg::CFG_SNOWFALL_THRESHOLD: begin
                    cfg_reg.snowfall_threshold <= cfg_data[9:0];
                end
                pvsnow_pkg::CFG_DEPTH_THRESHOLD: begin
                    cfg_reg.depth_threshold <= cfg_data[9:0];
                end
                pvsnow_pkg::CFG_IRRADIANCE_SLOPE: begin
                    cfg_reg.irradiance_slope <= cfg_data[7:0];
                end
                pvsnow_pkg::CFG_SLIDE_RATE:         cfg_reg.slide_rate <= cfg_data[9:0];
                pvsnow_pkg::CFG_TIME_STEP:          cfg_reg.time_step <= cfg_data[10:0];
                pvsnow_pkg::CFG_BAD_VALUE_LIMIT:    cfg_reg.bad_value_limit <= cfg_data;
            endcase
        end
    end

    // Sequencer
    pvsnow_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    pvsnow_dp #(
        .COVERAGE_FRACTION_BITS (COVERAGE_FRACTION_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .status        (status),
        .snow_depth    (s_tdata[14:0]),
        .depth_missing (s_tuser[0]),
        .irradiance    (s_tdata[25:15]),
        .panel_tilt    (s_tdata[36:26]),
        .air_temp      (s_tdata[47:37]),
        .sun_up        (s_tdata[48]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .loss_fraction (loss_fraction),
        .covered_rows  (covered_rows),
        .value_ok      (value_ok),
        .model_failed  (model_failed)
    );

    assign m_tdata = {covered_rows, loss_fraction};
    assign m_tuser = {model_failed, value_ok};

    // A failure word carries no loss and no valid flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 24'd0 && !m_tuser[0])
        else $error("failure word with nonzero loss fields");

    // Covered rows never exceed the rows of the array
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:16] <=
            ((cfg_reg.module_rows == 8'd0) ? 8'd1 : cfg_reg.module_rows))
        else $error("covered rows above module rows");

    // Loss fraction stays within one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] <= 16'd32768)
        else $error("loss fraction above one");

    // One sample at a time: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted sample");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the snow coverage step: stream stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_top;
    import pvsnow_pkg::*;

    localparam int     COV_BITS    = 15;
    localparam longint COV_FULL    = longint'(1) << COV_BITS;
    localparam longint SLIDE_DIV   = longint'(40960) << 15;
    localparam int     HOLD_CYCLES = 300;
    localparam int     PHASES      = 8;
    localparam int     PHASE_ITEMS = 166;

    // sin of whole degrees 0..90, Q1.15
    localparam int SINE_TABLE [0:90] = '{
        0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
        5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31652, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32768
    };

    typedef struct {
        logic signed [14:0] depth;
        logic               missing;
        logic [10:0]        poa;
        logic [10:0]        tilt;
        logic signed [10:0] temp;
        logic               sun;
    } weather_t;

    typedef struct {
        logic [15:0] loss;
        logic [7:0]  rows;
        logic        ok;
        logic        failed;
    } snow_loss_t;

    // Tracks coverage state, predicts each loss word and checks the results
    class snow_loss_tracker;
        int     rows_cfg, base_tilt, fall_thr, depth_thr;
        int     slope, rate, step_len, bad_limit;
        longint last_depth, coverage;
        int     bad_count;
        snow_loss_t pending_loss[$];
        int errors, samples, fails, bad_seen, slides, snowfalls, checked;

        function new();
            rows_cfg = 2; base_tilt = 480; fall_thr = 16; depth_thr = 16;
            slope = 80; rate = 504; step_len = 16; bad_limit = 500;
            last_depth = 0; coverage = 0; bad_count = 0;
            errors = 0; samples = 0; fails = 0; bad_seen = 0;
            slides = 0; snowfalls = 0; checked = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, int unsigned val);
            case (idx)
                CFG_MODULE_ROWS:        rows_cfg  = val & 'hFF;
                CFG_BASE_TILT:          base_tilt = val & 'h7FF;
                CFG_SNOWFALL_THRESHOLD: fall_thr  = val & 'h3FF;
                CFG_DEPTH_THRESHOLD:    depth_thr = val & 'h3FF;
                CFG_IRRADIANCE_SLOPE:   slope     = val & 'hFF;
                CFG_SLIDE_RATE:         rate      = val & 'h3FF;
                CFG_TIME_STEP:          step_len  = val & 'h7FF;
                CFG_BAD_VALUE_LIMIT:    bad_limit = val & 'hFFFF;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_loss.size();
        endfunction

        // Predict the loss word of one accepted sample
        function void take_sample(weather_t w);
            longint depth, temp, poa, cov, prod, amount, nrows, covered;
            int tilt_v, deg;
            snow_loss_t e;
            bit ok;
            depth = w.depth;
            temp = w.temp;
            poa = w.poa;
            tilt_v = w.tilt;
            ok = 1'b1;
            samples++;
            // bad depth counts as zero; failure only when the count lands on the limit
            if (w.missing || depth < 0 || depth > MAX_VALID_DEPTH) begin
                ok = 1'b0;
                depth = 0;
                bad_seen++;
                if (bad_count < 'hFFFF) begin
                    bad_count++;
                    if (bad_count == bad_limit) begin
                        e.loss = '0; e.rows = '0; e.ok = 1'b0; e.failed = 1'b1;
                        fails++;
                        pending_loss.push_back(e);
                        return;
                    end
                end
            end
            // new snowfall covers everything, shallow snow clears
            if ((depth - last_depth) * 16 >= longint'(fall_thr) * step_len &&
                depth >= depth_thr) begin
                cov = COV_FULL;
                snowfalls++;
            end else begin
                cov = coverage;
            end
            if (depth < depth_thr) cov = 0;
            if (!w.sun) tilt_v = base_tilt;
            // sliding off by a sine-of-tilt amount
            if (temp * slope + 16 * poa > 0) begin
                deg = (tilt_v + 8) >> 4;
                if (deg > 180) deg = 180;
                if (deg > 90) deg = 180 - deg;
                prod = longint'(rate) * SINE_TABLE[deg] * step_len;
                amount = ((prod << COV_BITS) + (SLIDE_DIV >> 1)) / SLIDE_DIV;
                cov = (amount >= cov) ? 0 : cov - amount;
                slides++;
            end
            // quantize up to whole rows
            nrows = (rows_cfg == 0) ? 1 : rows_cfg;
            covered = (cov * nrows + COV_FULL - 1) >> COV_BITS;
            e.loss = ((covered << 15) + (nrows >> 1)) / nrows;
            e.rows = covered;
            e.ok = ok;
            e.failed = 1'b0;
            last_depth = depth & 'h3FFF;
            coverage = cov;
            pending_loss.push_back(e);
        endfunction

        // Compare one result word with the oldest prediction
        function void match_result(logic [23:0] data, logic [1:0] user);
            snow_loss_t e;
            if (pending_loss.size() == 0) begin
                $display("%0t: unexpected result word loss %0d rows %0d flags %b",
                         $time, data[15:0], data[23:16], user);
                errors++;
                return;
            end
            e = pending_loss.pop_front();
            checked++;
            if (data[15:0] !== e.loss) begin
                $display("%0t: loss_fraction expected %0d got %0d", $time, e.loss, data[15:0]);
                errors++;
            end
            if (data[23:16] !== e.rows) begin
                $display("%0t: covered_rows expected %0d got %0d", $time, e.rows, data[23:16]);
                errors++;
            end
            if (user[0] !== e.ok) begin
                $display("%0t: value_ok expected %0b got %0b", $time, e.ok, user[0]);
                errors++;
            end
            if (user[1] !== e.failed) begin
                $display("%0t: model_failed expected %0b got %0b", $time, e.failed, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    snow_loss_tracker sb;
    bit  hold_req;
    bit  tx_steady;
    bit  rx_steady;
    int  depth_walk;
    int  settings_used;

    pv_snow_coverage_step u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(1, 3);
        if (r < 9) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic weather_t mk_weather(int depth, bit missing, int poa, int tilt,
                                            int temp, bit sun);
        weather_t w;
        w.depth = depth; w.missing = missing; w.poa = poa;
        w.tilt = tilt; w.temp = temp; w.sun = sun;
        return w;
    endfunction

    // Mostly plausible weather with random content, some broken depths
    function automatic weather_t random_weather();
        weather_t w;
        int r, t;
        r = $urandom_range(0, 99);
        w.missing = 1'b0;
        if (r < 6) begin
            case ($urandom_range(0, 2))
                0: begin w.missing = 1'b1; w.depth = $urandom_range(0, 32767); end
                1: w.depth = -int'($urandom_range(1, 16384));
                default: w.depth = $urandom_range(MAX_VALID_DEPTH + 1, 16383);
            endcase
        end else if (r < 10) begin
            w.depth = $urandom_range(0, 32767);
            w.missing = $urandom_range(0, 1);
        end else begin
            if (r < 22) begin
                depth_walk = depth_walk + $urandom_range(16, 3000);
            end else if (r < 32) begin
                depth_walk = $urandom_range(0, 2 * sb.depth_thr + 1);
            end else begin
                depth_walk = depth_walk + $urandom_range(0, 40) - 20;
            end
            if (depth_walk < 0) depth_walk = 0;
            if (depth_walk > MAX_VALID_DEPTH) depth_walk = MAX_VALID_DEPTH;
            w.depth = depth_walk;
        end
        w.temp = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2047)
                                             : -int'($urandom_range(0, 400));
        w.poa = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 2047);
        // close to the sliding boundary
        if ($urandom_range(0, 19) == 0) begin
            t = $urandom_range(1, 64);
            w.temp = -t;
            w.poa = (t * sb.slope) / 16 + $urandom_range(0, 1);
        end
        w.tilt = ($urandom_range(0, 9) == 0) ? $urandom_range(1441, 2047)
                                             : $urandom_range(0, 1440);
        w.sun = $urandom_range(0, 1);
        return w;
    endfunction

    // One sample word; entered and left at a falling edge
    task automatic send_sample(weather_t w);
        int gap;
        gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, w.sun, w.temp, w.tilt, w.poa, w.depth};
        s_tuser  = w.missing;
        do @(posedge aclk); while (!s_tready);
        sb.take_sample(w);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        s_tvalid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every predicted word has come back
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic int pick(int lo, int hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.match_result(m_tdata, m_tuser);
        end
    end

    // Receiver: random stalls, steady stretches, one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (!rx_steady && $urandom_range(0, 5) == 0) stall_left = idle_len();
            end
        end
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // Main sequence
    initial begin
        int lim;
        sb = new();
        hold_req = 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        depth_walk = 0;
        settings_used = 1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MODULE_ROWS;
        cfg_data = '0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset settings, snowfall, sliding boundary, tilt folding
        send_sample(mk_weather(0, 0, 0, 0, -1024, 1));
        send_sample(mk_weather(800, 0, 0, 0, -160, 1));
        send_sample(mk_weather(800, 0, 80, 480, -16, 1));
        send_sample(mk_weather(800, 0, 81, 480, -16, 1));
        send_sample(mk_weather(800, 0, 2047, 0, 1023, 0));
        send_sample(mk_weather(9760, 0, 0, 1440, -1024, 1));
        send_sample(mk_weather(9760, 0, 2047, 1440, 1023, 1));
        send_sample(mk_weather(9760, 0, 1, 2047, 0, 1));
        send_sample(mk_weather(9760, 0, 1365, 1448, 11'sh2AA, 1));
        send_sample(mk_weather(8, 0, 682, 1365, 11'sh555, 1));

        // limit of one fails on the very first bad depth
        drain();
        write_reg(CFG_BAD_VALUE_LIMIT, 1);
        send_sample(mk_weather(100, 1, 0, 0, 0, 1));
        drain();
        write_reg(CFG_BAD_VALUE_LIMIT, 500);
        send_sample(mk_weather(MAX_VALID_DEPTH + 1, 0, 0, 0, 0, 1));
        send_sample(mk_weather(-1, 0, 0, 0, 0, 1));
        send_sample(mk_weather(-16384, 0, 0, 0, 0, 1));
        send_sample(mk_weather(16383, 0, 0, 0, 0, 1));
        send_sample(mk_weather(0, 1, 0, 0, 0, 1));
        send_sample(mk_weather(5461, 0, 0, 0, 0, 1));
        send_sample(mk_weather(15'sh2AAA, 0, 0, 0, 0, 1));

        // limit reached exactly once, then passed
        drain();
        write_reg(CFG_BAD_VALUE_LIMIT, sb.bad_count + 2);
        send_sample(mk_weather(-5, 0, 0, 0, 0, 1));
        send_sample(mk_weather(0, 1, 0, 0, 0, 1));
        send_sample(mk_weather(-5, 0, 0, 0, 0, 1));
        send_sample(mk_weather(1000, 0, 0, 0, -100, 1));

        // random phases under changing register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            lim = sb.bad_count + $urandom_range(1, 30);
            if (lim > 65535) lim = 65535;
            case (ph)
                0: begin
                    write_reg(CFG_MODULE_ROWS, 2);
                    write_reg(CFG_BASE_TILT, 480);
                    write_reg(CFG_SNOWFALL_THRESHOLD, 16);
                    write_reg(CFG_DEPTH_THRESHOLD, 16);
                    write_reg(CFG_IRRADIANCE_SLOPE, 80);
                    write_reg(CFG_SLIDE_RATE, 504);
                    write_reg(CFG_TIME_STEP, 16);
                    write_reg(CFG_BAD_VALUE_LIMIT, lim);
                end
                1: begin
                    // zero rows acts as one row, zero slope slides on any sun
                    write_reg(CFG_MODULE_ROWS, 0);
                    write_reg(CFG_BASE_TILT, 0);
                    write_reg(CFG_SNOWFALL_THRESHOLD, 0);
                    write_reg(CFG_DEPTH_THRESHOLD, 0);
                    write_reg(CFG_IRRADIANCE_SLOPE, 0);
                    write_reg(CFG_SLIDE_RATE, 0);
                    write_reg(CFG_TIME_STEP, 1);
                    write_reg(CFG_BAD_VALUE_LIMIT, 1);
                end
                2: begin
                    write_reg(CFG_MODULE_ROWS, 255);
                    write_reg(CFG_BASE_TILT, 1440);
                    write_reg(CFG_SNOWFALL_THRESHOLD, 1023);
                    write_reg(CFG_DEPTH_THRESHOLD, 1023);
                    write_reg(CFG_IRRADIANCE_SLOPE, 255);
                    write_reg(CFG_SLIDE_RATE, 1023);
                    write_reg(CFG_TIME_STEP, 1024);
                    write_reg(CFG_BAD_VALUE_LIMIT, 65535);
                end
                default: begin
                    write_reg(CFG_MODULE_ROWS, pick(0, 255));
                    write_reg(CFG_BASE_TILT, pick(0, 1440));
                    write_reg(CFG_SNOWFALL_THRESHOLD, pick(0, 1023));
                    write_reg(CFG_DEPTH_THRESHOLD, pick(0, 1023));
                    write_reg(CFG_IRRADIANCE_SLOPE, pick(0, 255));
                    write_reg(CFG_SLIDE_RATE, pick(0, 1023));
                    write_reg(CFG_TIME_STEP, pick(1, 1024));
                    write_reg(CFG_BAD_VALUE_LIMIT, lim);
                end
            endcase
            settings_used++;
            if (ph == 5) begin
                tx_steady = 1'b1;
                rx_steady = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == 20) hold_req = 1'b1;
                if (ph == 4 && n == 80) drain();
                if (ph == 5 && n == 60) begin
                    tx_steady = 1'b0;
                    rx_steady = 1'b0;
                end
                send_sample(random_weather());
            end
        end

        // wind down
        drain();
        repeat (40) @(posedge aclk);
        $display("Ran %0d samples over %0d register settings, %0d words checked.",
                 sb.samples, settings_used, sb.checked);
        $display("Bad depths %0d, failing steps %0d, snowfalls %0d, slides %0d.",
                 sb.bad_seen, sb.fails, sb.snowfalls, sb.slides);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
